// ===== rtl/raa_pkg.sv =====
`default_nettype none
package raa_pkg;

  localparam int unsigned DimW = 13;
  localparam int unsigned KeyW = DimW + 1;
  localparam int unsigned AreaW = 2 * DimW;
  localparam int unsigned PosW = 12;

  typedef struct packed {
    logic [DimW-1:0] h;
    logic [DimW-1:0] w;
    logic [DimW-1:0] y;
    logic [DimW-1:0] x;
  } zone_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_NOFIT = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_RESET  = 1'b1
  } op_e;

  // split of a zone around a placed rectangle
  typedef struct packed {
    logic  exact;
    zone_t right;
    zone_t lower;
  } split_t;

  function automatic logic [KeyW-1:0] zone_key(zone_t z);
    return {1'b0, z.w} + {1'b0, z.h};
  endfunction

endpackage
`default_nettype wire

// ===== rtl/rect_atlas_allocator.sv =====
// Channel   Dir  Handshake                   Payload
// s_axis    in   s_axis_tvalid/s_axis_tready tdata: req_width, req_height; tuser: operation
// m_axis    out  m_axis_tvalid/m_axis_tready tdata: pos_x, pos_y; tuser: status
// apb       in   psel/penable/pwrite/pready  atlas_width at 0x0, atlas_height at 0x4
//
// An insert scans the list from the last entry down, cut short once FIT_WINDOW entries
// have been read from the first fit on, evaluates the split in S_EVAL, S_MULA, S_MULB and
// S_DECIDE, then makes up to three passes over the list (delete, insert piece, insert
// second piece) of one entry per cycle, set by the single read and write port of the
// zone memory. A reset request and a request on an empty list go straight to S_DONE.
// After rst_ni the block writes the whole atlas into entry 0 in S_INIT.
// A result waits in the output register while m_axis_tready is low; the next request
// is taken meanwhile, and its result holds back until the output register frees.
`default_nettype none
module rect_atlas_allocator
  import raa_pkg::*;
#(
  parameter int unsigned MAX_ZONES  = 64,
  parameter int unsigned FIT_WINDOW = 10
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [12:0] req_width, [25:13] req_height
  input  wire logic        s_axis_tuser,   // [0] operation
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [11:0] pos_x, [23:12] pos_y
  output logic [1:0]       m_axis_tuser,   // [1:0] status
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned AW = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
  localparam int unsigned CW = $clog2(MAX_ZONES + 1);
  localparam int unsigned LW = $clog2(FIT_WINDOW + 1);

  typedef enum logic [10:0] {
    S_INIT   = 11'b000_0000_0001,
    S_IDLE   = 11'b000_0000_0010,
    S_SCAN   = 11'b000_0000_0100,
    S_EVAL   = 11'b000_0000_1000,
    S_MULA   = 11'b000_0001_0000,
    S_MULB   = 11'b000_0010_0000,
    S_DECIDE = 11'b000_0100_0000,
    S_DEL    = 11'b000_1000_0000,
    S_INS    = 11'b001_0000_0000,
    S_INSW   = 11'b010_0000_0000,
    S_DONE   = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [DimW-1:0] atlas_w_q, atlas_h_q;
  logic            cfg_wr;

  // request and search state
  logic [DimW-1:0] rw_q, rw_d, rh_q, rh_d;
  logic [CW-1:0]   count_q, count_d, len_q, len_d;
  logic [CW-1:0]   issue_cnt_q, issue_cnt_d, proc_cnt_q, proc_cnt_d;
  logic [LW-1:0]   left_q, left_d;
  logic            found_q, found_d;
  logic [AW-1:0]   best_q, best_d;
  logic [KeyW-1:0] best_key_q, best_key_d;
  zone_t           bz_q, bz_d;

  // split evaluation
  split_t          split;
  zone_t           pa_q, pa_d, pb_q, pb_d;
  logic [AreaW-1:0] area_a_q, area_a_d, area_b_q, area_b_d;
  logic [DimW-1:0] mul_x, mul_y;
  logic [AreaW-1:0] mul_p;
  zone_t           pz_q, pz_d, qz_q, qz_d;
  logic            has_q_q, has_q_d, ins_p_q, ins_p_d, exact_q, exact_d;

  // list passes
  logic [AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   rd_rem_q, rd_rem_d;

  // result
  status_e         res_st_q, res_st_d;
  logic [PosW-1:0] res_x_q, res_x_d, res_y_q, res_y_d;
  logic            m_valid_q, m_valid_d;
  status_e         out_st_q, out_st_d;
  logic [PosW-1:0] out_x_q, out_x_d, out_y_q, out_y_d;

  // zone memory
  zone_t           mem [MAX_ZONES];
  logic            we;
  logic [AW-1:0]   waddr, raddr, rtag_q;
  zone_t           wdata, rdata_q;
  logic            issue_req, issue, rvld_q;

  // scan and insert compares on the word just read
  logic            fit, take, found_n, scan_end, after;
  logic [KeyW-1:0] rkey, xkey;
  logic [LW-1:0]   left_n;
  zone_t           xz, whole;
  logic            in_acc;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = paddr[2] ? {{(32-DimW){1'b0}}, atlas_h_q} : {{(32-DimW){1'b0}}, atlas_w_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atlas_w_q <= DimW'(1024);
      atlas_h_q <= DimW'(1024);
    end else if (cfg_wr) begin
      if (paddr[2]) atlas_h_q <= pwdata[DimW-1:0];
      else          atlas_w_q <= pwdata[DimW-1:0];
    end
  end

  assign whole = '{x: '0, y: '0, w: atlas_w_q, h: atlas_h_q};

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  raa_split u_split (
    .zone_i  (bz_q),
    .req_w_i (rw_q),
    .req_h_i (rh_q),
    .split_o (split)
  );

  // shared multiplier: right piece area, then lower piece area
  assign mul_x = (state_q == S_MULA) ? pa_q.w : pb_q.w;
  assign mul_y = (state_q == S_MULA) ? pa_q.h : pb_q.h;
  assign mul_p = {{DimW{1'b0}}, mul_x} * {{DimW{1'b0}}, mul_y};

  assign rkey     = zone_key(rdata_q);
  assign fit      = (rdata_q.w >= rw_q) && (rdata_q.h >= rh_q);
  assign take     = fit && (!found_q || rkey < best_key_q);
  assign found_n  = found_q || fit;
  assign left_n   = found_n ? left_q - LW'(1) : left_q;
  assign scan_end = rvld_q && ((left_n == '0) || (proc_cnt_q + CW'(1) == count_q));

  assign xz    = ins_p_q ? pz_q : qz_q;
  assign xkey  = zone_key(xz);
  // the word read goes behind the new piece: smaller key, or equal key and later index
  assign after = (rkey < xkey) || (ins_p_q && (rkey == xkey) && (rtag_q >= best_q));

  always_comb begin
    state_d     = state_q;
    rw_d        = rw_q;
    rh_d        = rh_q;
    count_d     = count_q;
    len_d       = len_q;
    issue_cnt_d = issue_cnt_q;
    proc_cnt_d  = proc_cnt_q;
    left_d      = left_q;
    found_d     = found_q;
    best_d      = best_q;
    best_key_d  = best_key_q;
    bz_d        = bz_q;
    pa_d        = pa_q;
    pb_d        = pb_q;
    area_a_d    = area_a_q;
    area_b_d    = area_b_q;
    pz_d        = pz_q;
    qz_d        = qz_q;
    has_q_d     = has_q_q;
    ins_p_d     = ins_p_q;
    exact_d     = exact_q;
    rd_ptr_d    = rd_ptr_q;
    rd_rem_d    = rd_rem_q;
    res_st_d    = res_st_q;
    res_x_d     = res_x_q;
    res_y_d     = res_y_q;
    m_valid_d   = m_valid_q;
    out_st_d    = out_st_q;
    out_x_d     = out_x_q;
    out_y_d     = out_y_q;
    we          = 1'b0;
    waddr       = '0;
    wdata       = xz;
    issue_req   = 1'b0;
    raddr       = rd_ptr_q;

    // drop the output once taken
    if (m_valid_q && m_axis_tready) m_valid_d = 1'b0;

    unique case (state_q)
      S_INIT: begin
        we      = 1'b1;
        wdata   = whole;
        count_d = CW'(1);
        state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          rw_d     = s_axis_tdata[DimW-1:0];
          rh_d     = s_axis_tdata[2*DimW-1:DimW];
          res_st_d = STAT_OK;
          res_x_d  = '0;
          res_y_d  = '0;
          if (s_axis_tuser == OP_RESET) begin
            we      = 1'b1;
            wdata   = whole;
            count_d = CW'(1);
            state_d = S_DONE;
          end else if (count_q == '0) begin
            res_st_d = STAT_NOFIT;
            state_d  = S_DONE;
          end else begin
            issue_cnt_d = '0;
            proc_cnt_d  = '0;
            left_d      = LW'(FIT_WINDOW);
            found_d     = 1'b0;
            state_d     = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // walk from the last entry down, one read per cycle
        issue_req = (issue_cnt_q < count_q);
        raddr     = AW'(count_q - CW'(1) - issue_cnt_q);
        if (issue_req) issue_cnt_d = issue_cnt_q + CW'(1);
        if (rvld_q) begin
          proc_cnt_d = proc_cnt_q + CW'(1);
          left_d     = left_n;
          found_d    = found_n;
          if (take) begin
            best_d     = rtag_q;
            best_key_d = rkey;
            bz_d       = rdata_q;
          end
        end
        if (scan_end) begin
          if (!found_n) begin
            res_st_d = STAT_NOFIT;
            state_d  = S_DONE;
          end else begin
            state_d = S_EVAL;
          end
        end
      end
      S_EVAL: begin
        res_x_d = bz_q.x[PosW-1:0];
        res_y_d = bz_q.y[PosW-1:0];
        pa_d    = split.right;
        pb_d    = split.lower;
        exact_d = split.exact;
        if (split.exact) begin
          rd_rem_d = count_q - CW'(best_q) - CW'(1);
          rd_ptr_d = best_q + AW'(1);
          state_d  = S_DEL;
        end else begin
          state_d = S_MULA;
        end
      end
      S_MULA: begin
        area_a_d = mul_p;
        state_d  = S_MULB;
      end
      S_MULB: begin
        area_b_d = mul_p;
        state_d  = S_DECIDE;
      end
      S_DECIDE: begin
        priority if (area_a_q == '0) begin
          pz_d    = pb_q;
          has_q_d = 1'b0;
        end else if (area_b_q == '0) begin
          pz_d    = pa_q;
          has_q_d = 1'b0;
        end else if (count_q >= CW'(MAX_ZONES)) begin
          res_st_d = STAT_FULL;
          res_x_d  = '0;
          res_y_d  = '0;
        end else if (area_a_q < area_b_q) begin
          pz_d    = pb_q;
          qz_d    = pa_q;
          has_q_d = 1'b1;
        end else begin
          pz_d    = pa_q;
          qz_d    = pb_q;
          has_q_d = 1'b1;
        end
        ins_p_d  = 1'b1;
        rd_rem_d = count_q - CW'(best_q) - CW'(1);
        rd_ptr_d = best_q + AW'(1);
        if ((area_a_q != '0) && (area_b_q != '0) && (count_q >= CW'(MAX_ZONES))) begin
          state_d = S_DONE;
        end else begin
          state_d = S_DEL;
        end
      end
      S_DEL: begin
        // close the gap at the chosen entry
        issue_req = (rd_rem_q != '0);
        if (issue_req) begin
          rd_ptr_d = rd_ptr_q + AW'(1);
          rd_rem_d = rd_rem_q - CW'(1);
        end
        if (rvld_q) begin
          we    = 1'b1;
          waddr = rtag_q - AW'(1);
          wdata = rdata_q;
        end
        if ((rd_rem_q == '0) && !rvld_q) begin
          len_d = count_q - CW'(1);
          if (exact_q) begin
            count_d = count_q - CW'(1);
            state_d = S_DONE;
          end else begin
            rd_ptr_d = AW'(count_q - CW'(2));
            rd_rem_d = count_q - CW'(1);
            state_d  = S_INS;
          end
        end
      end
      S_INS: begin
        // walk down from the end, moving each word up one until the slot is found
        if (rvld_q) begin
          we    = 1'b1;
          waddr = rtag_q + AW'(1);
          wdata = after ? rdata_q : xz;
        end
        priority if ((rd_rem_q == '0) && !rvld_q) begin
          waddr   = '0;
          state_d = S_INSW;
        end else if (rvld_q && after && (rtag_q == '0)) begin
          state_d = S_INSW;
        end else if (rvld_q && !after) begin
          len_d = len_q + CW'(1);
          if (ins_p_q && has_q_q) begin
            ins_p_d  = 1'b0;
            rd_ptr_d = AW'(len_q);
            rd_rem_d = len_q + CW'(1);
          end else begin
            count_d = len_q + CW'(1);
            state_d = S_DONE;
          end
        end else begin
          issue_req = (rd_rem_q != '0);
          if (issue_req) begin
            rd_ptr_d = rd_ptr_q - AW'(1);
            rd_rem_d = rd_rem_q - CW'(1);
          end
        end
      end
      S_INSW: begin
        we    = 1'b1;
        waddr = '0;
        wdata = xz;
        len_d = len_q + CW'(1);
        if (ins_p_q && has_q_q) begin
          ins_p_d  = 1'b0;
          rd_ptr_d = AW'(len_q);
          rd_rem_d = len_q + CW'(1);
          state_d  = S_INS;
        end else begin
          count_d = len_q + CW'(1);
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          out_st_d  = res_st_q;
          out_x_d   = res_x_q;
          out_y_d   = res_y_q;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_INIT;
    endcase

    // no read when the state moves on
    issue = issue_req && (state_d == state_q);
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
    rtag_q  <= raddr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_INIT;
      count_q   <= CW'(1);
      m_valid_q <= 1'b0;
      rvld_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      m_valid_q <= m_valid_d;
      rvld_q    <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    rw_q        <= rw_d;
    rh_q        <= rh_d;
    len_q       <= len_d;
    issue_cnt_q <= issue_cnt_d;
    proc_cnt_q  <= proc_cnt_d;
    left_q      <= left_d;
    found_q     <= found_d;
    best_q      <= best_d;
    best_key_q  <= best_key_d;
    bz_q        <= bz_d;
    pa_q        <= pa_d;
    pb_q        <= pb_d;
    area_a_q    <= area_a_d;
    area_b_q    <= area_b_d;
    pz_q        <= pz_d;
    qz_q        <= qz_d;
    has_q_q     <= has_q_d;
    ins_p_q     <= ins_p_d;
    exact_q     <= exact_d;
    rd_ptr_q    <= rd_ptr_d;
    rd_rem_q    <= rd_rem_d;
    res_st_q    <= res_st_d;
    res_x_q     <= res_x_d;
    res_y_q     <= res_y_d;
    out_st_q    <= out_st_d;
    out_x_q     <= out_x_d;
    out_y_q     <= out_y_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = out_st_q;
  assign m_axis_tdata  = {out_y_q, out_x_q};

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_ZONES))
    else $error("zone count beyond capacity");

  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && !in_acc) |-> !we)
    else $error("zone memory written while idle");

  a_err_no_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && out_st_q != STAT_OK) |-> (out_x_q == '0 && out_y_q == '0))
    else $error("position reported on a failed request");

  a_fail_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && res_st_q != STAT_OK) |-> $stable(count_q))
    else $error("zone count changed on a failed request");

endmodule
`default_nettype wire

// ===== rtl/raa_split.sv =====
`default_nettype none
module raa_split
  import raa_pkg::*;
(
  input  zone_t           zone_i,
  input  logic [DimW-1:0] req_w_i,
  input  logic [DimW-1:0] req_h_i,
  output split_t          split_o
);

  logic [DimW-1:0] dw, dh;

  assign dw = zone_i.w - req_w_i;
  assign dh = zone_i.h - req_h_i;

  always_comb begin
    split_o.exact   = (zone_i.w == req_w_i) && (zone_i.h == req_h_i);
    split_o.right.x = zone_i.x + req_w_i;
    split_o.right.y = zone_i.y;
    split_o.right.w = dw;
    split_o.lower.x = zone_i.x;
    split_o.lower.y = zone_i.y + req_h_i;
    split_o.lower.h = dh;
    // cut along the longer leftover
    if (dh > dw) begin
      split_o.right.h = req_h_i;
      split_o.lower.w = zone_i.w;
    end else begin
      split_o.right.h = zone_i.h;
      split_o.lower.w = req_w_i;
    end
  end

endmodule
`default_nettype wire
